// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL that carries checks; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The expression must never be true.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

`endif

// ===== rtl/clrb_pkg.sv =====
// Shared types and constants of the console log ring buffer.
package clrb_pkg;

    localparam int CHAR_W  = 8;
    localparam int OFF_W   = 10;
    localparam int CNT_W   = 10;

    localparam logic [CHAR_W-1:0] CH_PROMPT = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;

    // Kind of result loaded into the output register.
    typedef enum logic [2:0] {
        SEL_PROMPT,
        SEL_SPACE,
        SEL_CHAR,
        SEL_NONE,
        SEL_READ
    } t_sel;

    typedef struct packed {
        logic capture;
        logic push;
        logic push_cr;
        logic rd_issue;
        logic load_out;
        t_sel sel;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic ch_is_lf;
    } t_dp_status;

endpackage

// ===== rtl/clrb_ctrl.sv =====
// Controller state machine of the console log ring buffer.
module clrb_ctrl
    import clrb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_req_type,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_PUSH_CH,
        S_RD,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_echo;
    logic   r_line_start;
    t_sel   r_sel;
    logic   r_out_valid;

    logic in_acc;
    logic out_free;
    logic ch_done;
    t_sel char_sel;

    always_comb begin
        in_acc   = (r_state == S_IDLE) && i_in_valid;
        out_free = !r_out_valid || i_out_ready;
        // The character itself is stored in this cycle.
        ch_done  = ((r_state == S_WR) && !i_status.ch_is_lf) || (r_state == S_PUSH_CH);
        if (!r_echo) begin
            char_sel = SEL_NONE;
        end else if (r_line_start) begin
            char_sel = SEL_PROMPT;
        end else begin
            char_sel = SEL_CHAR;
        end

        o_cmd.capture  = in_acc;
        o_cmd.push     = (r_state == S_WR) || (r_state == S_PUSH_CH);
        o_cmd.push_cr  = (r_state == S_WR) && i_status.ch_is_lf;
        o_cmd.rd_issue = (r_state == S_RD);
        o_cmd.load_out = (r_state == S_EMIT) && out_free;
        o_cmd.sel      = r_sel;
        o_cmd.last     = (r_sel != SEL_PROMPT) && (r_sel != SEL_SPACE);
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_echo       <= 1'b1;
            r_line_start <= 1'b0;
            r_sel        <= SEL_NONE;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_echo <= i_cfg_wdata;
            end

            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (ch_done) begin
                r_sel <= char_sel;
                if (r_echo) begin
                    r_line_start <= i_status.ch_is_lf;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= i_req_type ? S_RD : S_WR;
                    end
                end
                S_WR: begin
                    r_state <= i_status.ch_is_lf ? S_PUSH_CH : S_EMIT;
                end
                S_PUSH_CH: begin
                    r_state <= S_EMIT;
                end
                S_RD: begin
                    r_sel   <= SEL_READ;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (o_cmd.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_sel <= (r_sel == SEL_PROMPT) ? SEL_SPACE : SEL_CHAR;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/clrb_datapath.sv =====
// Datapath of the console log ring buffer: ring memory, pointers and result register.
module clrb_datapath
    import clrb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic [OFF_W-1:0]  i_read_offset,
    output logic              o_uart_valid,
    output logic [CHAR_W-1:0] o_uart_byte,
    output logic              o_read_valid,
    output logic [CHAR_W-1:0] o_read_byte,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int FW = PW + 1;
    localparam int CW = (PW > OFF_W) ? PW : OFF_W;
    localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [CHAR_W-1:0] mem [DEPTH];

    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     r_op;
    logic [CHAR_W-1:0] r_ch;
    logic [OFF_W-1:0]  r_off;
    logic [CHAR_W-1:0] r_rd_data;
    logic              r_hit;

    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     n_op;
    logic [FW-1:0]     fill_w;
    logic [PW-1:0]     fill;
    logic              hit;
    logic [FW-1:0]     idx_sum;
    logic [PW-1:0]     rd_idx;
    logic [CHAR_W-1:0] push_byte;

    logic              n_uart_valid;
    logic [CHAR_W-1:0] n_uart_byte;
    logic              n_read_valid;
    logic [CHAR_W-1:0] n_read_byte;

    always_comb begin
        // The ring is empty when both pointers match, so it holds DEPTH-1 at most.
        if (r_wp >= r_op) begin
            fill_w = {1'b0, r_wp} - {1'b0, r_op};
        end else begin
            fill_w = {1'b0, r_wp} + DEPTH_F - {1'b0, r_op};
        end
        fill = fill_w[PW-1:0];
        hit  = CW'(r_off) < CW'(fill);

        // A hit offset is below the fill, so one conditional subtract wraps it.
        idx_sum = {1'b0, r_op} + {1'b0, PW'(r_off)};
        if (idx_sum >= DEPTH_F) begin
            rd_idx = PW'(idx_sum - DEPTH_F);
        end else begin
            rd_idx = idx_sum[PW-1:0];
        end

        n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
        n_op = (r_op == LAST_PTR) ? '0 : r_op + 1'b1;
        push_byte = i_cmd.push_cr ? CH_CR : r_ch;

        o_status.ch_is_lf = (r_ch == CH_LF);

        n_uart_valid = 1'b0;
        n_uart_byte  = '0;
        n_read_valid = 1'b0;
        n_read_byte  = '0;
        case (i_cmd.sel)
            SEL_PROMPT: begin
                n_uart_valid = 1'b1;
                n_uart_byte  = CH_PROMPT;
            end
            SEL_SPACE: begin
                n_uart_valid = 1'b1;
                n_uart_byte  = CH_SPACE;
            end
            SEL_CHAR: begin
                n_uart_valid = 1'b1;
                n_uart_byte  = r_ch;
            end
            SEL_READ: begin
                n_read_valid = r_hit;
                n_read_byte  = r_hit ? r_rd_data : '0;
            end
            default: begin
                n_uart_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_op <= '0;
        end else if (i_cmd.push) begin
            r_wp <= n_wp;
            if (n_wp == r_op) begin
                r_op <= n_op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_wp] <= push_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[rd_idx];
            r_hit     <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch  <= i_char_in;
            r_off <= i_read_offset;
        end
        if (i_cmd.load_out) begin
            o_uart_valid <= n_uart_valid;
            o_uart_byte  <= n_uart_byte;
            o_read_valid <= n_read_valid;
            o_read_byte  <= n_read_byte;
            o_fill_count <= CNT_W'(fill);
            o_last       <= i_cmd.last;
        end
    end

endmodule

// ===== rtl/console_log_ring_buffer_top.sv =====
// Top level of the console log ring buffer: controller, datapath and checks.
//
// Each write transaction stores one character in a ring of DEPTH bytes (a line
// feed is stored as carriage return then line feed, and the oldest byte is dropped
// when the ring is full) and, with UART echo on, returns one result per UART byte
// with a "> " prefix at each line start after a line feed (not on the first line
// after reset); with echo off it returns one result. A read transaction returns
// the byte at an offset from the oldest stored byte, without removing it, plus
// the fill count. One transaction is handled at a time. The ring memory has a
// single port, which stores one byte or performs one registered read per cycle,
// and the single output register presents one result per cycle while the
// receiver keeps taking results. The input side accepts the next transaction
// while the final result still waits in the output register. No clearing pass
// is needed after reset.
`include "assert_macros.svh"

module console_log_ring_buffer_top
    import clrb_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_req_type,
    input  logic [CHAR_W-1:0] i_char_in,
    input  logic [OFF_W-1:0]  i_read_offset,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_uart_valid,
    output logic [CHAR_W-1:0] o_uart_byte,
    output logic              o_read_valid,
    output logic [CHAR_W-1:0] o_read_byte,
    output logic [CNT_W-1:0]  o_fill_count,
    output logic              o_last,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    clrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    clrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_char_in     (i_char_in),
        .i_read_offset (i_read_offset),
        .o_uart_valid  (o_uart_valid),
        .o_uart_byte   (o_uart_byte),
        .o_read_valid  (o_read_valid),
        .o_read_byte   (o_read_byte),
        .o_fill_count  (o_fill_count),
        .o_last        (o_last)
    );

    // The single memory port never sees a store and a read in one cycle.
    `ASSERT_NEVER(a_port_conflict, i_clk, i_rst_n, w_cmd.push && w_cmd.rd_issue)
    // After a transaction is accepted the block is busy with it.
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // A result with a valid read byte is always a single, final result with no UART byte.
    `ASSERT_IMP(a_read_is_last, i_clk, i_rst_n, o_out_valid && o_read_valid,
        o_last && !o_uart_valid)

endmodule
